@@ hw/rtl/motor_force_to_throttle_core_assert.svh @@
// ----------------------------------------------------------------------------
// motor force to throttle assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef MOTOR_FORCE_TO_THROTTLE_CORE_ASSERT_SVH
`define MOTOR_FORCE_TO_THROTTLE_CORE_ASSERT_SVH

// same-cycle implication
`define MFT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mft_pkg.sv @@
// ----------------------------------------------------------------------------
// mft_pkg
// shared constants and types of the force to throttle pipeline
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam int MOTOR_COUNT   = 4;
    localparam int FRACTION_BITS = 16;
    localparam int FX_W          = FRACTION_BITS + 1;
    localparam int FORCE_W       = 32;
    localparam int MAXF_W        = 31;
    localparam int PROD_W        = 2 * FX_W;
    localparam int D_W           = 2 * FX_W + 2;
    localparam int ROOT_W        = FX_W + 1;
    localparam int REM_W         = ROOT_W + 2;
    localparam int SQRT_STAGES   = D_W / 2;
    localparam int DIV_STAGES    = FRACTION_BITS;
    localparam int LATENCY       = 1 + DIV_STAGES + 1 + (SQRT_STAGES + 1) + 1 + DIV_STAGES + 1;

    localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRACTION_BITS;

    localparam logic REG_FORCE_MAX = 1'b0;
    localparam logic REG_FACTOR    = 1'b1;

    typedef logic [FX_W-1:0] fx_t;

    typedef struct packed {
        logic [MAXF_W-1:0] maxf;
        fx_t               a;
        fx_t               b;
        logic [PROD_W-1:0] bb;
    } mft_coef_t;

endpackage

@@ hw/rtl/motor_force_to_throttle_core.sv @@
// ----------------------------------------------------------------------------
// motor_force_to_throttle_core
// four motor force demands in, four throttle commands out, via an inverted
// quadratic thrust model
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with force_0..force_3, signed Q16.16
// output channel: out_valid / out_stall with throttle_0..throttle_3, Q1.16
// one output beat per input beat, in order
// each beat passes through the two one-bit-per-stage dividers (16 stages each)
// and the square root (18 stages)
// throughput: one beat per cycle while no output stall freezes the pipeline, four lanes work side by side
// a stall while an output beat waits freezes the whole pipeline and raises
// in_stall in the same cycle; a stall with no output beat waiting is ignored
// reset clears the valid pipeline and loads the register defaults
// registers over apb: 0x0 maximum motor force, 0x4 thrust curve weight
// write registers only while no beat is in flight
// ----------------------------------------------------------------------------
`include "motor_force_to_throttle_core_assert.svh"

module motor_force_to_throttle_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mft_pkg::FORCE_W-1:0]      force_0,
    input  logic [mft_pkg::FORCE_W-1:0]      force_1,
    input  logic [mft_pkg::FORCE_W-1:0]      force_2,
    input  logic [mft_pkg::FORCE_W-1:0]      force_3,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mft_pkg::fx_t                     throttle_0,
    output mft_pkg::fx_t                     throttle_1,
    output mft_pkg::fx_t                     throttle_2,
    output mft_pkg::fx_t                     throttle_3
);

    localparam int L = mft_pkg::LATENCY;
    localparam int M = mft_pkg::MOTOR_COUNT;

    logic [mft_pkg::MAXF_W-1:0]  maxf_reg;
    mft_pkg::fx_t                factor_reg;
    logic [L-1:0]                vld_reg;
    logic                        adv;
    logic                        wr;
    mft_pkg::mft_coef_t          coef;
    mft_pkg::fx_t                a_eff;
    logic [mft_pkg::FORCE_W-1:0] force_vec [0:M-1];
    mft_pkg::fx_t                thr_vec   [0:M-1];

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxf_reg   <= mft_pkg::MAXF_W'(655360);
            factor_reg <= '0;
        end
        else if (wr)
        begin
            case (paddr[2])
                mft_pkg::REG_FORCE_MAX: maxf_reg   <= pwdata[mft_pkg::MAXF_W-1:0];
                mft_pkg::REG_FACTOR:    factor_reg <= pwdata[mft_pkg::FX_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mft_pkg::REG_FORCE_MAX: prdata = {1'b0, maxf_reg};
            mft_pkg::REG_FACTOR:    prdata = {15'b0, factor_reg};
            default:                prdata = '0;
        endcase
    end

    // coefficients shared by all lanes
    assign a_eff     = (factor_reg > mft_pkg::FX_ONE) ? mft_pkg::FX_ONE : factor_reg;
    assign coef.a    = a_eff;
    assign coef.b    = mft_pkg::FX_ONE - a_eff;
    assign coef.bb   = coef.b * coef.b;
    assign coef.maxf = (maxf_reg == '0) ? mft_pkg::MAXF_W'(1) : maxf_reg;

    // pipeline control
    assign adv       = !(vld_reg[L-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], in_valid};
    end

    assign force_vec[0] = force_0;
    assign force_vec[1] = force_1;
    assign force_vec[2] = force_2;
    assign force_vec[3] = force_3;

    for (genvar m = 0; m < M; m++)
    begin : g_lane
        mft_lane u_lane (
            .clk      (clk),
            .adv      (adv),
            .coef     (coef),
            .force_in (force_vec[m]),
            .throttle (thr_vec[m])
        );
    end

    assign throttle_0 = thr_vec[0];
    assign throttle_1 = thr_vec[1];
    assign throttle_2 = thr_vec[2];
    assign throttle_3 = thr_vec[3];

    `MFT_ASSERT_IMP(a_thr0_range, out_valid, throttle_0 <= mft_pkg::FX_ONE, "throttle_0 above one")
    `MFT_ASSERT_IMP(a_thr3_range, out_valid, throttle_3 <= mft_pkg::FX_ONE, "throttle_3 above one")
    `MFT_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_reg[0], "accepted beat lost")
    `MFT_ASSERT_NXT(a_freeze, !adv, $stable(vld_reg), "pipeline moved while frozen")

endmodule

@@ hw/rtl/mft_isqrt.sv @@
// ----------------------------------------------------------------------------
// mft_isqrt
// forms b*b + 4*a*rel and takes its floor square root, one root bit a stage
// ----------------------------------------------------------------------------
module mft_isqrt (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [mft_pkg::PROD_W-1:0]     bb,
    input  logic [mft_pkg::PROD_W-1:0]     prod,
    input  mft_pkg::fx_t                   rel_in,
    output logic [mft_pkg::ROOT_W-1:0]     root,
    output mft_pkg::fx_t                   rel_out
);

    localparam int N = mft_pkg::SQRT_STAGES;

    logic [mft_pkg::D_W-1:0]    dd_reg   [0:N];
    logic [mft_pkg::REM_W-1:0]  rem_reg  [0:N];
    logic [mft_pkg::ROOT_W-1:0] root_reg [0:N];
    mft_pkg::fx_t               rel_reg  [0:N];

    logic [mft_pkg::D_W-1:0]    dd_next   [1:N];
    logic [mft_pkg::REM_W-1:0]  rem_next  [1:N];
    logic [mft_pkg::ROOT_W-1:0] root_next [1:N];

    always_comb
    begin
        logic [mft_pkg::REM_W+1:0] wide;
        logic [mft_pkg::REM_W+1:0] trial;
        for (int k = 1; k <= N; k++)
        begin
            wide  = {rem_reg[k-1], dd_reg[k-1][mft_pkg::D_W-1 -: 2]};
            trial = {2'b00, root_reg[k-1], 2'b01};
            if (wide >= trial)
            begin
                rem_next[k]  = mft_pkg::REM_W'(wide - trial);
                root_next[k] = {root_reg[k-1][mft_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = mft_pkg::REM_W'(wide);
                root_next[k] = {root_reg[k-1][mft_pkg::ROOT_W-2:0], 1'b0};
            end
            dd_next[k] = dd_reg[k-1] << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_reg[0]   <= {2'b00, bb} + {prod, 2'b00};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rel_reg[0]  <= rel_in;
            for (int k = 1; k <= N; k++)
            begin
                dd_reg[k]   <= dd_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rel_reg[k]  <= rel_reg[k-1];
            end
        end
    end

    assign root    = root_reg[N];
    assign rel_out = rel_reg[N];

endmodule

@@ hw/rtl/mft_lane.sv @@
// ----------------------------------------------------------------------------
// mft_lane
// one motor: relative thrust divide, thrust model inversion, throttle divide
// ----------------------------------------------------------------------------
module mft_lane (
    input  logic                            clk,
    input  logic                            adv,
    input  mft_pkg::mft_coef_t              coef,
    input  logic [mft_pkg::FORCE_W-1:0]     force_in,
    output mft_pkg::fx_t                    throttle
);

    localparam int N   = mft_pkg::DIV_STAGES;
    localparam int QW  = mft_pkg::FRACTION_BITS;
    localparam int MW  = mft_pkg::MAXF_W;
    localparam int R2W = mft_pkg::FX_W + 1;

    // relative thrust divider
    logic [MW-1:0] r1_reg   [0:N];
    logic [QW-1:0] q1_reg   [0:N];
    logic          pos1_reg [0:N];
    logic          sat1_reg [0:N];
    logic [MW-1:0] r1_next  [1:N];
    logic [QW-1:0] q1_next  [1:N];

    // throttle divider
    logic [R2W-1:0]     r2_reg   [0:N];
    logic [QW-1:0]      q2_reg   [0:N];
    logic               sat2_reg [0:N];
    mft_pkg::fx_t       rel2_reg [0:N];
    logic [R2W-1:0]     r2_next  [1:N];
    logic [QW-1:0]      q2_next  [1:N];

    logic [mft_pkg::PROD_W-1:0] prod_reg;
    mft_pkg::fx_t               relm_reg;
    mft_pkg::fx_t               rel;
    logic [mft_pkg::ROOT_W-1:0] root;
    mft_pkg::fx_t               rel_sq;
    logic [R2W-1:0]             two_a;
    logic [R2W-1:0]             diff;
    logic                       pos;
    mft_pkg::fx_t               throttle_reg;

    assign pos   = !force_in[mft_pkg::FORCE_W-1] && (force_in != '0);
    assign two_a = {coef.a, 1'b0};

    always_comb
    begin
        logic [MW:0]  sh1;
        logic [R2W:0] sh2;
        for (int k = 1; k <= N; k++)
        begin
            sh1 = {r1_reg[k-1], 1'b0};
            if (sh1 >= {1'b0, coef.maxf})
            begin
                r1_next[k] = MW'(sh1 - {1'b0, coef.maxf});
                q1_next[k] = {q1_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                r1_next[k] = sh1[MW-1:0];
                q1_next[k] = {q1_reg[k-1][QW-2:0], 1'b0};
            end
            sh2 = {r2_reg[k-1], 1'b0};
            if (sh2 >= {1'b0, two_a})
            begin
                r2_next[k] = R2W'(sh2 - {1'b0, two_a});
                q2_next[k] = {q2_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                r2_next[k] = sh2[R2W-1:0];
                q2_next[k] = {q2_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (!pos1_reg[N])
            rel = '0;
        else if (sat1_reg[N])
            rel = mft_pkg::FX_ONE;
        else
            rel = {1'b0, q1_reg[N]};
    end

    assign diff = (root < {1'b0, coef.b}) ? '0 : (root - {1'b0, coef.b});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg[0]   <= force_in[MW-1:0];
            q1_reg[0]   <= '0;
            pos1_reg[0] <= pos;
            sat1_reg[0] <= force_in[MW-1:0] >= coef.maxf;
            for (int k = 1; k <= N; k++)
            begin
                r1_reg[k]   <= r1_next[k];
                q1_reg[k]   <= q1_next[k];
                pos1_reg[k] <= pos1_reg[k-1];
                sat1_reg[k] <= sat1_reg[k-1];
            end

            prod_reg <= coef.a * rel;
            relm_reg <= rel;

            r2_reg[0]   <= diff;
            q2_reg[0]   <= '0;
            sat2_reg[0] <= diff >= two_a;
            rel2_reg[0] <= rel_sq;
            for (int k = 1; k <= N; k++)
            begin
                r2_reg[k]   <= r2_next[k];
                q2_reg[k]   <= q2_next[k];
                sat2_reg[k] <= sat2_reg[k-1];
                rel2_reg[k] <= rel2_reg[k-1];
            end

            if (coef.a == '0)
                throttle_reg <= rel2_reg[N];
            else if (sat2_reg[N])
                throttle_reg <= mft_pkg::FX_ONE;
            else
                throttle_reg <= {1'b0, q2_reg[N]};
        end
    end

    mft_isqrt u_isqrt (
        .clk     (clk),
        .adv     (adv),
        .bb      (coef.bb),
        .prod    (prod_reg),
        .rel_in  (relm_reg),
        .root    (root),
        .rel_out (rel_sq)
    );

    assign throttle = throttle_reg;

endmodule

@@ tb/tb_motor_force_to_throttle_core.sv @@
// ----------------------------------------------------------------------------
// tb_motor_force_to_throttle_core
// drives force beats with random gaps, stalls the throttle side at random,
// predicts each throttle beat in fixed point and compares the whole beat
// ----------------------------------------------------------------------------
module tb_motor_force_to_throttle_core;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] ADDR_FORCE_MAX = {mft_pkg::REG_FORCE_MAX, 2'b00};
    localparam logic [2:0] ADDR_FACTOR    = {mft_pkg::REG_FACTOR, 2'b00};

    typedef struct packed {
        mft_pkg::fx_t t0;
        mft_pkg::fx_t t1;
        mft_pkg::fx_t t2;
        mft_pkg::fx_t t3;
    } throttle_set_t;

    class throttle_scoreboard;
        throttle_set_t pending[$];
        logic [30:0] maxf_reg;
        mft_pkg::fx_t factor_reg;
        int mismatches;
        int checked;

        function new();
            maxf_reg = 31'd655360;
            factor_reg = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function mft_pkg::fx_t force_to_throttle(logic [31:0] f);
            longint unsigned one;
            longint unsigned mx;
            longint unsigned rel;
            longint unsigned a;
            longint unsigned b;
            longint unsigned s;
            longint unsigned u;
            one = 64'd1 << mft_pkg::FRACTION_BITS;
            if (f == 0 || f[31])
                rel = 0;
            else
            begin
                mx = (maxf_reg == 0) ? 1 : maxf_reg;
                rel = ({32'd0, f} << mft_pkg::FRACTION_BITS) / mx;
                if (rel > one)
                    rel = one;
            end
            a = factor_reg;
            if (a > one)
                a = one;
            if (a == 0)
                return mft_pkg::fx_t'(rel);
            b = one - a;
            s = int_sqrt(b * b + 4 * a * rel);
            if (s < b)
                s = b;
            u = ((s - b) << mft_pkg::FRACTION_BITS) / (2 * a);
            if (u > one)
                u = one;
            return mft_pkg::fx_t'(u);
        endfunction

        function void note_forces(logic [31:0] f0, logic [31:0] f1,
                                  logic [31:0] f2, logic [31:0] f3);
            throttle_set_t e;
            e.t0 = force_to_throttle(f0);
            e.t1 = force_to_throttle(f1);
            e.t2 = force_to_throttle(f2);
            e.t3 = force_to_throttle(f3);
            pending.push_back(e);
        endfunction

        function void check_throttles(throttle_set_t got);
            throttle_set_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected throttle beat %h", got);
                return;
            end
            e = pending.pop_front();
            if (e != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("throttle mismatch exp %h/%h/%h/%h got %h/%h/%h/%h",
                             e.t0, e.t1, e.t2, e.t3, got.t0, got.t1, got.t2, got.t3);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic [31:0] force_0, force_1, force_2, force_3;
    logic out_valid, out_stall;
    mft_pkg::fx_t throttle_0, throttle_1, throttle_2, throttle_3;

    throttle_scoreboard sb;
    int idle_cycles;
    bit hold_off;
    int sent;

    motor_force_to_throttle_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [31:0] pick_force();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return $urandom;
            1: return -$urandom_range(0, 1000);
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            default: return $urandom_range(0, 2 * sb.maxf_reg + 2);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_FORCE_MAX)
            sb.maxf_reg = data[30:0];
        else
            sb.factor_reg = data[mft_pkg::FX_W-1:0];
    endtask

    task automatic send_forces(input logic [31:0] f0, input logic [31:0] f1,
                               input logic [31:0] f2, input logic [31:0] f3);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        force_0 <= f0;
        force_1 <= f1;
        force_2 <= f2;
        force_3 <= f3;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_forces(f0, f1, f2, f3);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (mft_pkg::LATENCY + 5) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        repeat (count)
            send_forces(pick_force(), pick_force(), pick_force(), pick_force());
    endtask

    // output side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_throttles({throttle_0, throttle_1, throttle_2, throttle_3});
            if (hold_off)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[motor_force_to_throttle_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        idle_cycles = 0;
        hold_off = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        force_0 = '0;
        force_1 = '0;
        force_2 = '0;
        force_3 = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats, first under reset defaults, then with written registers
        send_forces(32'd0, 32'hffffffff, 32'h80000000, 32'h7fffffff);
        send_forces(32'd655360, 32'd327680, 32'd1, 32'd655361);
        drain();
        apb_write(ADDR_FACTOR, 32'd32768);
        send_forces(32'd0, 32'd655360, 32'd327680, 32'd65536);
        send_forces(32'd1, 32'h7fffffff, 32'hfffffffe, 32'd163840);
        drain();
        apb_write(ADDR_FORCE_MAX, 32'd0);
        apb_write(ADDR_FACTOR, 32'd65536);
        send_forces(32'd1, 32'd0, 32'h80000000, 32'd2);
        drain();
        apb_write(ADDR_FORCE_MAX, 32'h7fffffff);
        apb_write(ADDR_FACTOR, 32'h0001ffff);
        send_forces(32'h7fffffff, 32'h3fffffff, 32'd1, 32'hffffffff);
        send_forces(32'h55555555, 32'h2aaaaaaa, 32'h00ffffff, 32'h7ffffffe);
        drain();

        // long receiver hold-off while beats keep coming
        apb_write(ADDR_FORCE_MAX, 32'd655360);
        apb_write(ADDR_FACTOR, 32'd16384);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(120);
        join
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(ADDR_FORCE_MAX, (ph % 3 == 0) ? $urandom : $urandom_range(0, 2000000));
            apb_write(ADDR_FACTOR, (ph == 5) ? 32'd0 : $urandom_range(0, 70000));
            random_phase(100);
            drain();
        end

        $display("sent %0d force beats, checked %0d throttle beats", sent, sb.checked);
        $display("covered corner forces, a long receiver hold-off and random register values");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[motor_force_to_throttle_core] OK");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("[motor_force_to_throttle_core] ERROR");
        end
        $finish;
    end
endmodule
